// ----- design/rpa_pkg.sv -----
// shared types and constants for the refcounted page allocator
package rpa_pkg;

   localparam int PAGE_W   = 15;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 8;

   localparam int NUM_PAGES_DEF      = 32768;
   localparam int RESERVED_PAGES_DEF = 32;
   localparam int COUNT_MAX_DEF      = 255;
   localparam int COUNT_LIMIT        = 255;

   // small queues between the parts
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_SHARE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_FREE,
      OP_SHARE,
      OP_RANGE
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_RANGE     = 3'd2,
      ST_FREED     = 3'd3,
      ST_SHAREFREE = 3'd4,
      ST_SAT       = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      BK_SWEEP,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      op_type            op;
      logic [PAGE_W-1:0] page;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } cmd_link_type;

   typedef struct packed {
      logic take;
      logic sweeping;
   } back_ctl_type;

   typedef struct packed {
      logic [PAGE_W-1:0]  frame;
      status_type         status;
      logic               released;
      logic [COUNT_W-1:0] ref_count;
   } result_type;

   typedef struct packed {
      logic       push;
      result_type result;
   } rsp_link_type;

endpackage

// ----- design/rpa_front.sv -----
// front part: classifies requests and holds them in a short command queue
module rpa_front #(
   parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [rpa_pkg::CMD_W-1:0]    req_command,
   input  logic [rpa_pkg::PAGE_W-1:0]   req_page,
   output rpa_pkg::cmd_link_type        link,
   input  rpa_pkg::back_ctl_type        ctl
);
   import rpa_pkg::*;

   item_type             q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   item_type             item_in;
   logic                 in_range;
   logic                 accept;

   assign in_range = 32'(req_page) < 32'(NUM_PAGES);

   always_comb begin
      item_in.page = req_page;
      case (req_command)
         CMD_ALLOC: item_in.op = OP_ALLOC;
         CMD_FREE:  item_in.op = in_range ? OP_FREE : OP_RANGE;
         CMD_SHARE: item_in.op = in_range ? OP_SHARE : OP_RANGE;
         default:   item_in.op = OP_RANGE;
      endcase
   end

   // no requests taken while the back part clears its memories
   assign full   = (cnt_ff == Q_CNT_W'(Q_DEPTH)) || ctl.sweeping;
   assign accept = push && !full;

   assign link.valid = (cnt_ff != '0);
   assign link.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? Q_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = ctl.take ? Q_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = Q_CNT_W'(cnt_ff + {{(Q_CNT_W-1){1'b0}}, accept}
                          - {{(Q_CNT_W-1){1'b0}}, ctl.take});
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_take_when_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.take |-> (cnt_ff != '0))
      else $error("command taken from empty queue");

endmodule

// ----- design/rpa_back.sv -----
// back part: count memory, free stack, reset sweep and command execution
module rpa_back #(
   parameter int NUM_PAGES      = rpa_pkg::NUM_PAGES_DEF,
   parameter int RESERVED_PAGES = rpa_pkg::RESERVED_PAGES_DEF,
   parameter int COUNT_MAX      = rpa_pkg::COUNT_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rpa_pkg::cmd_link_type  link,
   output rpa_pkg::back_ctl_type  ctl,
   output rpa_pkg::rsp_link_type  rsp,
   input  logic                   rsp_room
);
   import rpa_pkg::*;

   localparam int IDX_W     = $clog2(NUM_PAGES);
   localparam int DEPTH_W   = $clog2(NUM_PAGES + 1);
   localparam int RES_EFF   = (RESERVED_PAGES < NUM_PAGES) ? RESERVED_PAGES : NUM_PAGES;
   localparam int FREE_INIT = NUM_PAGES - RES_EFF;
   localparam int COUNT_CAP = (COUNT_MAX < COUNT_LIMIT) ? COUNT_MAX : COUNT_LIMIT;

   logic [COUNT_W-1:0] cnt_mem [NUM_PAGES];
   logic [IDX_W-1:0]   stk_mem [NUM_PAGES];

   back_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    sweep_ff, sweep_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   op_type              op_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [COUNT_W-1:0]  rd_cnt_ff;
   logic [IDX_W-1:0]    rd_stk_ff;

   logic                cnt_we;
   logic [IDX_W-1:0]    cnt_wa;
   logic [COUNT_W-1:0]  cnt_wd;
   logic                stk_we;
   logic [IDX_W-1:0]    stk_wa;
   logic [IDX_W-1:0]    stk_wd;
   logic [IDX_W-1:0]    cnt_ra;
   logic [IDX_W-1:0]    stk_ra;
   logic [IDX_W-1:0]    page_addr;
   logic [COUNT_W-1:0]  cnt_dec;
   logic [COUNT_W-1:0]  cnt_inc;

   assign cnt_ra    = IDX_W'(link.item.page);
   assign stk_ra    = IDX_W'(depth_ff - DEPTH_W'(1));
   assign page_addr = IDX_W'(page_ff);
   assign cnt_dec   = rd_cnt_ff - COUNT_W'(1);
   assign cnt_inc   = rd_cnt_ff + COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_SWEEP;
         sweep_ff <= '0;
         depth_ff <= DEPTH_W'(FREE_INIT);
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         depth_ff <= depth_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      depth_in     = depth_ff;
      ctl.take     = 1'b0;
      ctl.sweeping = (state_ff == BK_SWEEP);
      rsp.push     = 1'b0;
      rsp.result.frame     = page_ff;
      rsp.result.status    = ST_OK;
      rsp.result.released  = 1'b0;
      rsp.result.ref_count = '0;
      cnt_we = 1'b0;
      cnt_wa = page_addr;
      cnt_wd = '0;
      stk_we = 1'b0;
      stk_wa = sweep_ff;
      stk_wd = '0;
      case (state_ff)
         BK_SWEEP: begin
            // reserved frames start at one reference, stack entry k holds frame k + reserved
            cnt_we = 1'b1;
            cnt_wa = sweep_ff;
            cnt_wd = (32'(sweep_ff) < 32'(RES_EFF)) ? COUNT_W'(1) : '0;
            stk_we = 1'b1;
            stk_wa = sweep_ff;
            stk_wd = IDX_W'(32'(sweep_ff) + 32'(RES_EFF));
            if (sweep_ff == IDX_W'(NUM_PAGES - 1)) begin
               state_in = BK_IDLE;
            end else begin
               sweep_in = IDX_W'(sweep_ff + 1'b1);
            end
         end
         BK_IDLE: begin
            if (link.valid && rsp_room) begin
               ctl.take = 1'b1;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            rsp.push = 1'b1;
            state_in = BK_IDLE;
            case (op_ff)
               OP_ALLOC: begin
                  if (depth_ff == '0) begin
                     rsp.result.frame  = '0;
                     rsp.result.status = ST_EMPTY;
                  end else begin
                     depth_in = DEPTH_W'(depth_ff - DEPTH_W'(1));
                     cnt_we   = 1'b1;
                     cnt_wa   = rd_stk_ff;
                     cnt_wd   = COUNT_W'(1);
                     rsp.result.frame     = PAGE_W'(rd_stk_ff);
                     rsp.result.ref_count = COUNT_W'(1);
                  end
               end
               OP_FREE: begin
                  if (rd_cnt_ff == '0) begin
                     rsp.result.status = ST_FREED;
                  end else begin
                     cnt_we = 1'b1;
                     cnt_wd = cnt_dec;
                     if (cnt_dec == '0) begin
                        rsp.result.released = 1'b1;
                        if (32'(depth_ff) < 32'(NUM_PAGES)) begin
                           stk_we   = 1'b1;
                           stk_wa   = IDX_W'(depth_ff);
                           stk_wd   = page_addr;
                           depth_in = DEPTH_W'(depth_ff + DEPTH_W'(1));
                        end
                     end else begin
                        rsp.result.ref_count = cnt_dec;
                     end
                  end
               end
               OP_SHARE: begin
                  if (rd_cnt_ff == '0) begin
                     rsp.result.status = ST_SHAREFREE;
                  end else if (rd_cnt_ff >= COUNT_W'(COUNT_CAP)) begin
                     rsp.result.status    = ST_SAT;
                     rsp.result.ref_count = rd_cnt_ff;
                  end else begin
                     cnt_we = 1'b1;
                     cnt_wd = cnt_inc;
                     rsp.result.ref_count = cnt_inc;
                  end
               end
               default: begin
                  rsp.result.status = ST_RANGE;
               end
            endcase
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // memories: one write port each, reads registered when a command is taken
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      if (ctl.take) begin
         rd_cnt_ff <= cnt_mem[cnt_ra];
         rd_stk_ff <= stk_mem[stk_ra];
         op_ff     <= link.item.op;
         page_ff   <= link.item.page;
      end
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      32'(depth_ff) <= 32'(NUM_PAGES))
      else $error("free stack depth beyond pool size");

   a_take_then_exec: assert property (@(posedge clock) disable iff (reset)
      ctl.take |=> (state_ff == BK_EXEC && rsp.push))
      else $error("taken command not executed next cycle");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp.push |-> rsp_room)
      else $error("result pushed into full queue");

   a_alloc_pops: assert property (@(posedge clock) disable iff (reset)
      (rsp.push && op_ff == OP_ALLOC && rsp.result.status == ST_OK)
         |=> (depth_ff == DEPTH_W'($past(depth_ff) - DEPTH_W'(1))))
      else $error("allocate did not pop the free stack");

endmodule

// ----- design/rpa_rsp.sv -----
// result queue facing the consumer
module rpa_rsp (
   input  logic                          clock,
   input  logic                          reset,
   input  rpa_pkg::rsp_link_type         link,
   output logic                          room,
   output logic                          empty,
   input  logic                          pop,
   output logic [rpa_pkg::PAGE_W-1:0]    rsp_frame,
   output logic [rpa_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_released,
   output logic [rpa_pkg::COUNT_W-1:0]   rsp_ref_count
);
   import rpa_pkg::*;

   result_type           q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                 take;
   result_type           head;

   assign room  = (cnt_ff != Q_CNT_W'(Q_DEPTH));
   assign empty = (cnt_ff == '0);
   assign take  = pop && !empty;

   assign head          = q_ff[rd_ptr_ff];
   assign rsp_frame     = head.frame;
   assign rsp_status    = head.status;
   assign rsp_released  = head.released;
   assign rsp_ref_count = head.ref_count;

   always_comb begin
      wr_ptr_in = link.push ? Q_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = take ? Q_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = Q_CNT_W'(cnt_ff + {{(Q_CNT_W-1){1'b0}}, link.push}
                          - {{(Q_CNT_W-1){1'b0}}, take});
   end

   always_ff @(posedge clock) begin
      if (link.push) begin
         q_ff[wr_ptr_ff] <= link.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- design/refcounted_page_allocator_unit.sv -----
// top level of the refcounted page allocator
//
//   channel   ports                                          handshake
//   request   req_command, req_page                          push / full
//   result    rsp_frame, rsp_status, rsp_released,           empty / pop
//             rsp_ref_count
//
// each transaction occupies the execution part until written back: the count memory and
// the free stack top are read as the command is taken, then the result is computed and
// written back; a result passes the command queue, read registers and result queue
// after reset the block clears both memories with full held high
// a two-entry command queue and a two-entry result queue let either side stall
// the execution part waits while the result queue is full
module refcounted_page_allocator_unit #(
   parameter int NUM_PAGES      = rpa_pkg::NUM_PAGES_DEF,
   parameter int RESERVED_PAGES = rpa_pkg::RESERVED_PAGES_DEF,
   parameter int COUNT_MAX      = rpa_pkg::COUNT_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [rpa_pkg::CMD_W-1:0]     req_command,
   input  logic [rpa_pkg::PAGE_W-1:0]    req_page,
   output logic                          empty,
   input  logic                          pop,
   output logic [rpa_pkg::PAGE_W-1:0]    rsp_frame,
   output logic [rpa_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_released,
   output logic [rpa_pkg::COUNT_W-1:0]   rsp_ref_count
);
   import rpa_pkg::*;

   cmd_link_type  cmd_link;
   back_ctl_type  back_ctl;
   rsp_link_type  rsp_link;
   logic          rsp_room;

   rpa_front #(
      .NUM_PAGES (NUM_PAGES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_command (req_command),
      .req_page    (req_page),
      .link        (cmd_link),
      .ctl         (back_ctl)
   );

   rpa_back #(
      .NUM_PAGES      (NUM_PAGES),
      .RESERVED_PAGES (RESERVED_PAGES),
      .COUNT_MAX      (COUNT_MAX)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .link     (cmd_link),
      .ctl      (back_ctl),
      .rsp      (rsp_link),
      .rsp_room (rsp_room)
   );

   rpa_rsp u_rsp (
      .clock         (clock),
      .reset         (reset),
      .link          (rsp_link),
      .room          (rsp_room),
      .empty         (empty),
      .pop           (pop),
      .rsp_frame     (rsp_frame),
      .rsp_status    (rsp_status),
      .rsp_released  (rsp_released),
      .rsp_ref_count (rsp_ref_count)
   );

endmodule
